>>> rtl/key_press_event_detector_core_assert.svh
// Assertion macros used by the checker file of the key press event detector.
// Each macro expands to one labeled concurrent assertion on the rising edge of aclk,
// switched off while aresetn is low.
`ifndef KEY_PRESS_EVENT_DETECTOR_CORE_ASSERT_SVH
`define KEY_PRESS_EVENT_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define KPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// Types and constants shared by the key press event detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

    localparam int NUM_KEYS_DEFAULT = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DEB_W      = 8;
    localparam int CNT_W      = 16;
    localparam int EV_W       = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd2;

    // Register reset values.
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET   = 8'd2;
    localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd300;
    localparam logic [CNT_W-1:0] REPEAT_RESET     = 16'd15;

    // Event codes.
    localparam logic [EV_W-1:0] EV_CLICK     = 3'd0;
    localparam logic [EV_W-1:0] EV_LONG      = 3'd1;
    localparam logic [EV_W-1:0] EV_CLICK_REL = 3'd2;
    localparam logic [EV_W-1:0] EV_REPEAT    = 3'd3;
    localparam logic [EV_W-1:0] EV_LONG_REL  = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HELD     = 2'd2,
        PH_REPEAT   = 2'd3
    } kpd_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } kpd_state_t;

    typedef struct packed {
        logic load_tick;
        logic scan_step;
        logic emit_load;
    } kpd_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic ev_none;
        logic emit_last;
        logic out_free;
    } kpd_status_t;

endpackage

`default_nettype wire

>>> rtl/kpd_ctrl.sv
// ----------------------------------------------------------------------------
// kpd_ctrl
// Sequencer: takes a scan tick, walks the keys, then hands out the events.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  kpd_pkg::kpd_status_t      status,
    output kpd_pkg::kpd_cmd_t         cmd
);

    kpd_pkg::kpd_state_t state_reg;
    kpd_pkg::kpd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kpd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kpd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = kpd_pkg::ST_SCAN;
                end
            end
            kpd_pkg::ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = kpd_pkg::ST_EMIT;
                end
            end
            kpd_pkg::ST_EMIT: begin
                if (status.ev_none || (status.out_free && status.emit_last)) begin
                    state_next = kpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == kpd_pkg::ST_IDLE);
        cmd.load_tick = (state_reg == kpd_pkg::ST_IDLE) && s_valid;
        cmd.scan_step = (state_reg == kpd_pkg::ST_SCAN);
        cmd.emit_load = (state_reg == kpd_pkg::ST_EMIT) && !status.ev_none && status.out_free;
    end

endmodule

`default_nettype wire

>>> rtl/kpd_datapath.sv
// ----------------------------------------------------------------------------
// kpd_datapath
// Per-key state, configuration registers, shared key update logic,
// event buffer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_datapath #(
    parameter int NUM_KEYS = kpd_pkg::NUM_KEYS_DEFAULT,
    parameter int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [NUM_KEYS-1:0]             s_key_levels,
    input  wire logic                            cfg_valid,
    input  wire logic [kpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [kpd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            m_ready,
    output logic                                 m_valid,
    output logic [KEY_W-1:0]                     m_key_index,
    output logic [kpd_pkg::EV_W-1:0]             m_event_code,
    output logic                                 m_last_event,
    input  kpd_pkg::kpd_cmd_t                    cmd,
    output kpd_pkg::kpd_status_t                 status
);

    localparam int NCNT_W = $clog2(NUM_KEYS + 1);

    // Configuration registers.
    logic [kpd_pkg::DEB_W-1:0] dbt_reg;
    logic [kpd_pkg::CNT_W-1:0] lpt_reg;
    logic [kpd_pkg::CNT_W-1:0] rpt_reg;

    // Per-key state.
    kpd_pkg::kpd_phase_t       phase_reg    [NUM_KEYS];
    logic [kpd_pkg::DEB_W-1:0] deb_cnt_reg  [NUM_KEYS];
    logic [kpd_pkg::CNT_W-1:0] hold_cnt_reg [NUM_KEYS];
    logic [kpd_pkg::CNT_W-1:0] rep_cnt_reg  [NUM_KEYS];

    // Scan and event buffer.
    logic [NUM_KEYS-1:0]       levels_reg;
    logic [KEY_W-1:0]          scan_idx_reg;
    logic [KEY_W-1:0]          ev_key_reg   [NUM_KEYS];
    logic [kpd_pkg::EV_W-1:0]  ev_code_reg  [NUM_KEYS];
    logic [NCNT_W-1:0]         ev_count_reg;
    logic [KEY_W-1:0]          rd_ptr_reg;

    // Output register.
    logic                      m_valid_reg;
    logic [KEY_W-1:0]          m_key_index_reg;
    logic [kpd_pkg::EV_W-1:0]  m_event_code_reg;
    logic                      m_last_reg;

    // Update of the key under scan.
    kpd_pkg::kpd_phase_t       cur_phase;
    logic                      pressed;
    logic [kpd_pkg::DEB_W-1:0] deb_dec;
    logic [kpd_pkg::CNT_W-1:0] hold_dec;
    logic [kpd_pkg::CNT_W-1:0] rep_dec;
    kpd_pkg::kpd_phase_t       phase_next;
    logic [kpd_pkg::DEB_W-1:0] deb_next;
    logic [kpd_pkg::CNT_W-1:0] hold_next;
    logic [kpd_pkg::CNT_W-1:0] rep_next;
    logic                      fire;
    logic [kpd_pkg::EV_W-1:0]  code;

    always_comb begin
        cur_phase  = phase_reg[scan_idx_reg];
        pressed    = levels_reg[scan_idx_reg];
        deb_dec    = deb_cnt_reg[scan_idx_reg] - kpd_pkg::DEB_W'(1);
        hold_dec   = hold_cnt_reg[scan_idx_reg] - kpd_pkg::CNT_W'(1);
        rep_dec    = rep_cnt_reg[scan_idx_reg] - kpd_pkg::CNT_W'(1);
        phase_next = cur_phase;
        deb_next   = deb_cnt_reg[scan_idx_reg];
        hold_next  = hold_cnt_reg[scan_idx_reg];
        rep_next   = rep_cnt_reg[scan_idx_reg];
        fire       = 1'b0;
        code       = kpd_pkg::EV_CLICK;
        unique case (cur_phase)
            kpd_pkg::PH_IDLE: begin
                if (pressed) begin
                    phase_next = kpd_pkg::PH_DEBOUNCE;
                end
            end
            kpd_pkg::PH_DEBOUNCE: begin
                if (pressed) begin
                    deb_next = deb_dec;
                    if (deb_dec == '0) begin
                        deb_next   = dbt_reg;
                        phase_next = kpd_pkg::PH_HELD;
                        fire       = 1'b1;
                        code       = kpd_pkg::EV_CLICK;
                    end
                end else begin
                    deb_next   = dbt_reg;
                    phase_next = kpd_pkg::PH_IDLE;
                end
            end
            kpd_pkg::PH_HELD: begin
                if (pressed) begin
                    hold_next = hold_dec;
                    if (hold_dec == '0) begin
                        hold_next  = lpt_reg;
                        phase_next = kpd_pkg::PH_REPEAT;
                        fire       = 1'b1;
                        code       = kpd_pkg::EV_LONG;
                    end
                end else begin
                    hold_next  = lpt_reg;
                    phase_next = kpd_pkg::PH_IDLE;
                    fire       = 1'b1;
                    code       = kpd_pkg::EV_CLICK_REL;
                end
            end
            kpd_pkg::PH_REPEAT: begin
                if (pressed) begin
                    rep_next = rep_dec;
                    if (rep_dec == '0) begin
                        rep_next = rpt_reg;
                        fire     = 1'b1;
                        code     = kpd_pkg::EV_REPEAT;
                    end
                end else begin
                    rep_next   = rpt_reg;
                    phase_next = kpd_pkg::PH_IDLE;
                    fire       = 1'b1;
                    code       = kpd_pkg::EV_LONG_REL;
                end
            end
            default: begin
                phase_next = kpd_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        status.scan_done = (scan_idx_reg == KEY_W'(NUM_KEYS - 1));
        status.ev_none   = (ev_count_reg == '0);
        status.emit_last = ((NCNT_W'(rd_ptr_reg) + NCNT_W'(1)) == ev_count_reg);
        status.out_free  = !m_valid_reg || m_ready;
    end

    // Configuration writes; an unknown index is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbt_reg <= kpd_pkg::DEBOUNCE_RESET;
            lpt_reg <= kpd_pkg::LONG_PRESS_RESET;
            rpt_reg <= kpd_pkg::REPEAT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                kpd_pkg::CFG_DEBOUNCE:   dbt_reg <= cfg_data[kpd_pkg::DEB_W-1:0];
                kpd_pkg::CFG_LONG_PRESS: lpt_reg <= cfg_data;
                kpd_pkg::CFG_REPEAT:     rpt_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                phase_reg[k]    <= kpd_pkg::PH_IDLE;
                deb_cnt_reg[k]  <= kpd_pkg::DEBOUNCE_RESET;
                hold_cnt_reg[k] <= kpd_pkg::LONG_PRESS_RESET;
                rep_cnt_reg[k]  <= kpd_pkg::REPEAT_RESET;
            end
        end else if (cmd.scan_step) begin
            phase_reg[scan_idx_reg]    <= phase_next;
            deb_cnt_reg[scan_idx_reg]  <= deb_next;
            hold_cnt_reg[scan_idx_reg] <= hold_next;
            rep_cnt_reg[scan_idx_reg]  <= rep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            ev_count_reg <= '0;
            rd_ptr_reg   <= '0;
        end else if (cmd.load_tick) begin
            scan_idx_reg <= '0;
            ev_count_reg <= '0;
            rd_ptr_reg   <= '0;
        end else begin
            if (cmd.scan_step) begin
                if (!status.scan_done) begin
                    scan_idx_reg <= scan_idx_reg + KEY_W'(1);
                end
                if (fire) begin
                    ev_count_reg <= ev_count_reg + NCNT_W'(1);
                end
            end
            if (cmd.emit_load) begin
                rd_ptr_reg <= rd_ptr_reg + KEY_W'(1);
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (cmd.load_tick) begin
            levels_reg <= s_key_levels;
        end
        if (cmd.scan_step && fire) begin
            ev_key_reg[ev_count_reg[KEY_W-1:0]]  <= scan_idx_reg;
            ev_code_reg[ev_count_reg[KEY_W-1:0]] <= code;
        end
        if (cmd.emit_load) begin
            m_key_index_reg  <= ev_key_reg[rd_ptr_reg];
            m_event_code_reg <= ev_code_reg[rd_ptr_reg];
            m_last_reg       <= status.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_key_index  = m_key_index_reg;
    assign m_event_code = m_event_code_reg;
    assign m_last_event = m_last_reg;

endmodule

`default_nettype wire

>>> rtl/key_press_event_detector_core.sv
// ----------------------------------------------------------------------------
// key_press_event_detector_core
// Per-key click, long-press, repeat and release detector driven by scan ticks.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the s_ channel is one scan tick with the pressed level of every
// key in s_key_levels. Each key gives at most one event per tick; the events
// leave on the m_ channel in ascending key order and the final one of a tick
// has m_last_event set. A tick with no event produces nothing on m_.
// The three timing registers are written through cfg_valid/cfg_index/cfg_data
// (cfg_ready is always high); write them only while the block is idle.
// Scan: the keys are walked one per cycle through one shared update unit.
// s_ready stays low from acceptance until the scan is done and, if the tick
// has events, the last of them is loaded into the output register. The first
// event shows on m_valid once every key has been scanned; further events
// follow one per cycle while m_ready is high.
// A stalled receiver holds the current event in the output register and the
// block waits; once the last event of a tick is in that register, the next
// tick can be accepted.
// Reset puts every key in idle, loads the counters and registers with their
// defaults (2, 300, 15) and clears the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_event_detector_core #(
    parameter int NUM_KEYS = kpd_pkg::NUM_KEYS_DEFAULT,
    parameter int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [NUM_KEYS-1:0]             s_key_levels,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [KEY_W-1:0]                     m_key_index,
    output logic [kpd_pkg::EV_W-1:0]             m_event_code,
    output logic                                 m_last_event,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [kpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    kpd_pkg::kpd_cmd_t    cmd;
    kpd_pkg::kpd_status_t status;

    assign cfg_ready = 1'b1;

    kpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    kpd_datapath #(
        .NUM_KEYS (NUM_KEYS),
        .KEY_W    (KEY_W)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_key_levels (s_key_levels),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_key_index  (m_key_index),
        .m_event_code (m_event_code),
        .m_last_event (m_last_event),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

>>> rtl/kpd_checker.sv
// ----------------------------------------------------------------------------
// kpd_checker
// Port-level checks for the key press event detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_press_event_detector_core_assert.svh"

module kpd_checker #(
    parameter int NUM_KEYS = kpd_pkg::NUM_KEYS_DEFAULT,
    parameter int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic [NUM_KEYS-1:0]             s_key_levels,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [KEY_W-1:0]                m_key_index,
    input wire logic [kpd_pkg::EV_W-1:0]        m_event_code,
    input wire logic                            m_last_event,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready,
    input wire logic [kpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input wire logic [kpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic unused_ok;
    assign unused_ok = ^{s_key_levels, cfg_valid, cfg_ready, cfg_index, cfg_data};

    // A waiting event holds until it is taken.
    `KPD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_key_index) && $stable(m_event_code) && $stable(m_last_event), "event changed while stalled")

    // A tick is scanned after acceptance, so the input cannot be ready again at once.
    `KPD_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "input ready right after a tick")

    // No new tick while the current tick still has events to hand out.
    `KPD_ASSERT_SAME(a_no_tick_mid_burst, m_valid && !m_last_event, !s_ready, "tick accepted before last event")

    // Events only name existing keys.
    `KPD_ASSERT_SAME(a_key_range, m_valid, 32'(m_key_index) < NUM_KEYS, "key index out of range")

endmodule

bind key_press_event_detector_core kpd_checker #(
    .NUM_KEYS (NUM_KEYS),
    .KEY_W    (KEY_W)
) u_kpd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_key_levels (s_key_levels),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_key_index  (m_key_index),
    .m_event_code (m_event_code),
    .m_last_event (m_last_event),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for key_press_event_detector_core. Scan ticks go in
// through a valid/ready channel with random gaps, and the receiver stalls at
// random. A per-key phase tracker in the bench predicts the events of every
// accepted tick, and each event that leaves the block is compared with the
// oldest prediction. The run starts with a table of hand-picked ticks,
// continues with a zero debounce period, and ends with runs of key presses
// under several timing settings, the register extremes among them.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int KEYS          = 3;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_PHASES    = 7;

    // The block ignores writes to this index.
    localparam logic [kpd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]               key;
        logic [kpd_pkg::EV_W-1:0] code;
        logic                     last;
    } key_event_t;

    typedef key_event_t [0:2] tick_events_t;

    typedef struct packed {
        logic [KEYS-1:0] levels;
        logic            typed;
        logic [1:0]      n_ev;
        tick_events_t    ev;
    } tick_row_t;

    localparam key_event_t   NO_EV = '0;
    localparam tick_events_t NONE3 = '0;

    // Rows before FIRST_TUNED_ROW run with the reset timing (2, 300, 15), and
    // their events are typed in. The remaining rows run with every period at 1
    // and are checked against the phase tracker.
    localparam int NUM_DIRECTED    = 22;
    localparam int FIRST_TUNED_ROW = 6;

    tick_row_t directed_ticks [NUM_DIRECTED] = '{
        '{3'b000, 1'b1, 2'd0, NONE3},
        '{3'b001, 1'b1, 2'd0, NONE3},
        '{3'b001, 1'b1, 2'd0, NONE3},
        '{3'b001, 1'b1, 2'd1, {{2'd0, kpd_pkg::EV_CLICK, 1'b1}, NO_EV, NO_EV}},
        '{3'b100, 1'b1, 2'd1, {{2'd0, kpd_pkg::EV_CLICK_REL, 1'b1}, NO_EV, NO_EV}},
        '{3'b000, 1'b1, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b000, 1'b0, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b000, 1'b0, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b111, 1'b0, 2'd0, NONE3},
        '{3'b101, 1'b0, 2'd0, NONE3},
        '{3'b010, 1'b0, 2'd0, NONE3},
        '{3'b000, 1'b0, 2'd0, NONE3}
    };

    logic                           aclk         = 1'b0;
    logic                           aresetn      = 1'b0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic [KEYS-1:0]                s_key_levels = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic [1:0]                     m_key_index;
    logic [kpd_pkg::EV_W-1:0]       m_event_code;
    logic                           m_last_event;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [kpd_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [kpd_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

    // Phase tracker state and its copy of the timing registers.
    kpd_pkg::kpd_phase_t key_phase_now [KEYS];
    logic [7:0]          deb_left [KEYS];
    logic [15:0]         hold_left [KEYS];
    logic [15:0]         rpt_left [KEYS];
    logic [7:0]          deb_set;
    logic [15:0]         hold_set;
    logic [15:0]         rpt_set;

    key_event_t   pending_events [$];
    logic         row_typed = 1'b0;
    logic [1:0]   row_n     = '0;
    tick_events_t row_ev    = '0;

    logic idling_on = 1'b1;
    int   rx_hold   = 0;
    int   cycle_count = 0;
    int   mismatches = 0;
    int   ticks_sent = 0;
    int   events_checked = 0;
    int   settings_used = 1;
    int   code_hits [5] = '{0, 0, 0, 0, 0};

    key_press_event_detector_core #(
        .NUM_KEYS(KEYS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_levels(s_key_levels),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_key_index (m_key_index),
        .m_event_code(m_event_code),
        .m_last_event(m_last_event),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void reset_tracker();
        deb_set  = kpd_pkg::DEBOUNCE_RESET;
        hold_set = kpd_pkg::LONG_PRESS_RESET;
        rpt_set  = kpd_pkg::REPEAT_RESET;
        for (int k = 0; k < KEYS; k++) begin
            key_phase_now[k] = kpd_pkg::PH_IDLE;
            deb_left[k]      = deb_set;
            hold_left[k]     = hold_set;
            rpt_left[k]      = rpt_set;
        end
    endfunction

    function automatic void write_register(input logic [kpd_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [kpd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            kpd_pkg::CFG_DEBOUNCE:   deb_set  = data[7:0];
            kpd_pkg::CFG_LONG_PRESS: hold_set = data;
            kpd_pkg::CFG_REPEAT:     rpt_set  = data;
            default: ;
        endcase
    endfunction

    // Advances every key by one scan tick, hands out the events in key order and returns their number.
    function automatic int scan_tick(input logic [KEYS-1:0] levels,
                                     output tick_events_t evs);
        int                       n;
        logic                     fire;
        logic [kpd_pkg::EV_W-1:0] ev_code;
        n   = 0;
        evs = '0;
        for (int k = 0; k < KEYS; k++) begin
            fire    = 1'b0;
            ev_code = kpd_pkg::EV_CLICK;
            case (key_phase_now[k])
                kpd_pkg::PH_IDLE: begin
                    if (levels[k]) key_phase_now[k] = kpd_pkg::PH_DEBOUNCE;
                end
                kpd_pkg::PH_DEBOUNCE: begin
                    if (levels[k]) begin
                        deb_left[k] = deb_left[k] - 8'd1;
                        if (deb_left[k] == 8'd0) begin
                            deb_left[k]      = deb_set;
                            key_phase_now[k] = kpd_pkg::PH_HELD;
                            fire             = 1'b1;
                            ev_code          = kpd_pkg::EV_CLICK;
                        end
                    end else begin
                        deb_left[k]      = deb_set;
                        key_phase_now[k] = kpd_pkg::PH_IDLE;
                    end
                end
                kpd_pkg::PH_HELD: begin
                    if (levels[k]) begin
                        hold_left[k] = hold_left[k] - 16'd1;
                        if (hold_left[k] == 16'd0) begin
                            hold_left[k]     = hold_set;
                            key_phase_now[k] = kpd_pkg::PH_REPEAT;
                            fire             = 1'b1;
                            ev_code          = kpd_pkg::EV_LONG;
                        end
                    end else begin
                        hold_left[k]     = hold_set;
                        key_phase_now[k] = kpd_pkg::PH_IDLE;
                        fire             = 1'b1;
                        ev_code          = kpd_pkg::EV_CLICK_REL;
                    end
                end
                default: begin
                    if (levels[k]) begin
                        rpt_left[k] = rpt_left[k] - 16'd1;
                        if (rpt_left[k] == 16'd0) begin
                            rpt_left[k] = rpt_set;
                            fire        = 1'b1;
                            ev_code     = kpd_pkg::EV_REPEAT;
                        end
                    end else begin
                        rpt_left[k]      = rpt_set;
                        key_phase_now[k] = kpd_pkg::PH_IDLE;
                        fire             = 1'b1;
                        ev_code          = kpd_pkg::EV_LONG_REL;
                    end
                end
            endcase
            if (fire) begin
                evs[n] = {2'(k), ev_code, 1'b0};
                n++;
            end
        end
        if (n > 0) evs[n-1].last = 1'b1;
        return n;
    endfunction

    // Keys mostly keep their level so that presses last long enough to reach
    // the long-press and repeat phases; now and then a tick is pure noise.
    function automatic logic [KEYS-1:0] next_levels(input logic [KEYS-1:0] cur);
        logic [KEYS-1:0] nxt;
        nxt = cur;
        if ($urandom_range(0, 9) == 0) begin
            nxt = KEYS'($urandom_range(0, 7));
        end else begin
            for (int k = 0; k < KEYS; k++) begin
                if ($urandom_range(0, 5) == 0) nxt[k] = ~nxt[k];
            end
        end
        return nxt;
    endfunction

    // All driving tasks start and end on a falling edge.
    task automatic send_tick(input logic [KEYS-1:0] levels);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_key_levels = levels;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [kpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kpd_pkg::CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_events();
        s_valid = 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
    endtask

    // A tick without events leaves no trace in the queue, so the bench waits after
    // the drain to let the block finish its scan before the registers change.
    task automatic tune(input logic [kpd_pkg::CFG_DATA_W-1:0] deb,
                        input logic [kpd_pkg::CFG_DATA_W-1:0] hold,
                        input logic [kpd_pkg::CFG_DATA_W-1:0] rpt);
        drain_events();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_cfg(kpd_pkg::CFG_DEBOUNCE, deb);
        write_cfg(kpd_pkg::CFG_LONG_PRESS, hold);
        write_cfg(kpd_pkg::CFG_REPEAT, rpt);
        settings_used++;
    endtask

    always @(negedge aclk) begin
        if (!idling_on) begin
            m_ready = 1'b1;
        end else if (rx_hold != 0) begin
            rx_hold--;
            m_ready = 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(0, 10);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin : scoreboard
        int           n;
        tick_events_t evs;
        key_event_t   want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                n = scan_tick(s_key_levels, evs);
                if (row_typed) begin
                    n   = row_n;
                    evs = row_ev;
                end
                for (int i = 0; i < n; i++) pending_events.push_back(evs[i]);
            end
            if (m_valid && m_ready) begin
                events_checked++;
                if (m_event_code <= kpd_pkg::EV_LONG_REL) code_hits[m_event_code]++;
                if (pending_events.size() == 0) begin
                    $error("unexpected item: key_index %0d event_code %0d last_event %0d",
                           m_key_index, m_event_code, m_last_event);
                    mismatches++;
                end else begin
                    want = pending_events.pop_front();
                    if (m_key_index !== want.key) begin
                        $error("key_index: expected %0d, got %0d", want.key, m_key_index);
                        mismatches++;
                    end
                    if (m_event_code !== want.code) begin
                        $error("event_code: expected %0d, got %0d", want.code, m_event_code);
                        mismatches++;
                    end
                    if (m_last_event !== want.last) begin
                        $error("last_event: expected %0d, got %0d", want.last, m_last_event);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, pending_events.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        logic [KEYS-1:0] levels;
        int              n_items;
        levels = '0;
        reset_tracker();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            if (r == FIRST_TUNED_ROW) tune(16'd1, 16'd1, 16'd1);
            row_typed = directed_ticks[r].typed;
            row_n     = directed_ticks[r].n_ev;
            row_ev    = directed_ticks[r].ev;
            send_tick(directed_ticks[r].levels);
        end
        row_typed = 1'b0;

        // A zero debounce register gives a 256-tick debounce once the counter
        // has been reloaded, which the click and release below take care of.
        tune(16'd0, 16'd2, 16'd1);
        send_tick(3'b000);
        repeat (3) send_tick(3'b111);
        send_tick(3'b000);
        repeat (262) send_tick(3'b111);
        send_tick(3'b000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: tune(16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: tune(16'd1, 16'd1, 16'd1);
                2: tune(16'd3, 16'd5, 16'd2);
                NUM_PHASES - 1: tune(16'd2, 16'd6, 16'd3);
                default: tune(16'($urandom_range(1, 8)), 16'($urandom_range(1, 30)),
                              16'($urandom_range(1, 10)));
            endcase
            if (p == 0) write_cfg(CFG_UNUSED, 16'($urandom));
            idling_on = (p != NUM_PHASES - 1);
            n_items   = (p == 0) ? 11 : 12;
            for (int i = 0; i < n_items; i++) begin
                // Let the sender wait once per phase until every event is out.
                if (i == n_items / 2) drain_events();
                levels = next_levels(levels);
                send_tick(levels);
            end
        end

        drain_events();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("%0d scan ticks under %0d timing settings, %0d events checked",
                 ticks_sent, settings_used, events_checked);
        $display("clicks %0d, long presses %0d, click releases %0d, repeats %0d, long releases %0d",
                 code_hits[kpd_pkg::EV_CLICK], code_hits[kpd_pkg::EV_LONG],
                 code_hits[kpd_pkg::EV_CLICK_REL], code_hits[kpd_pkg::EV_REPEAT],
                 code_hits[kpd_pkg::EV_LONG_REL]);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
